### hw/rtl/csb_pkg.sv
// csb_pkg: shared widths, register indexes and the configuration struct
// for the clipped sprite blitter; no dependencies
package csb_pkg;

  localparam int XY_W   = 12;
  localparam int DIM_W  = 13;
  localparam int SUM_W  = 14;
  localparam int ADDR_W = 24;
  localparam int PIX_W  = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_DEST_X      = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEST_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPRITE_COLS = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPRITE_ROWS = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_COLS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAME_ROWS  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ZERO_CLEAR  = 3'd6;

  // effective (clamped) settings plus the precomputed blit start address
  typedef struct packed {
    logic [XY_W-1:0]   dest_x;
    logic [XY_W-1:0]   dest_y;
    logic [DIM_W-1:0]  scols;
    logic [DIM_W-1:0]  srows;
    logic [DIM_W-1:0]  fcols;
    logic [DIM_W-1:0]  frows;
    logic              zero_is_clear;
    logic [ADDR_W-1:0] base;
  } cfg_t;

endpackage

### hw/rtl/csb_cfg.sv
// csb_cfg: configuration registers, dimension clamping and the registered
// start address (frame_cols * dest_y + dest_x); depends on csb_pkg
module csb_cfg #(
  parameter int MAX_DIM = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [csb_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [csb_pkg::DIM_W-1:0] cfg_wdata_i,
  output csb_pkg::cfg_t             cfg_o
);
  import csb_pkg::*;

  localparam int DIM_CAP_INT = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_INT);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
  localparam int PROD_W = DIM_W + XY_W;

  logic [XY_W-1:0]   dest_x_q, dest_y_q;
  logic [DIM_W-1:0]  scols_q, srows_q, fcols_q, frows_q;
  logic              zclr_q;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [DIM_W-1:0]  fcols_eff;
  logic [PROD_W-1:0] prod;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_ONE;
    end else if (v > DIM_CAP) begin
      return DIM_CAP;
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      scols_q  <= DIM_ONE;
      srows_q  <= DIM_ONE;
      fcols_q  <= DIM_ONE;
      frows_q  <= DIM_ONE;
      zclr_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEST_X:      dest_x_q <= cfg_wdata_i[XY_W-1:0];
        REG_DEST_Y:      dest_y_q <= cfg_wdata_i[XY_W-1:0];
        REG_SPRITE_COLS: scols_q  <= cfg_wdata_i;
        REG_SPRITE_ROWS: srows_q  <= cfg_wdata_i;
        REG_FRAME_COLS:  fcols_q  <= cfg_wdata_i;
        REG_FRAME_ROWS:  frows_q  <= cfg_wdata_i;
        REG_ZERO_CLEAR:  zclr_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign fcols_eff = eff_dim(fcols_q);
  assign prod      = PROD_W'(fcols_eff) * PROD_W'(dest_y_q);
  assign base_d    = prod[ADDR_W-1:0] + ADDR_W'(dest_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= base_d;
    end
  end

  always_comb begin
    cfg_o.dest_x        = dest_x_q;
    cfg_o.dest_y        = dest_y_q;
    cfg_o.scols         = eff_dim(scols_q);
    cfg_o.srows         = eff_dim(srows_q);
    cfg_o.fcols         = fcols_eff;
    cfg_o.frows         = eff_dim(frows_q);
    cfg_o.zero_is_clear = zclr_q;
    cfg_o.base          = base_q;
  end

endmodule

### hw/rtl/clipped_sprite_blit.sv
// clipped_sprite_blit: top level of the clipped colour-key sprite blitter
// depends on csb_pkg and csb_cfg
// path: a pixel word is taken into the input register, then its write word into the result register
// throughput: one pixel word per cycle while the output is not stalled, set by the input register and result register
// the start address multiply is registered off the configuration, not in the pixel path
// reset: counters and tracking addresses clear, registers return to their defaults, no word pending
module clipped_sprite_blit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csb_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [csb_pkg::DIM_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [csb_pkg::PIX_W-1:0]  pixel_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [csb_pkg::ADDR_W-1:0] write_addr_o,
  output logic [csb_pkg::PIX_W-1:0]  write_colour_o
);
  import csb_pkg::*;

  localparam int CNT_W = (MAX_DIM > 8192) ? DIM_W : $clog2(MAX_DIM);

  cfg_t cfg;

  logic              in_valid_q;
  logic [PIX_W-1:0]  pixel_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] waddr_q, waddr_d;
  logic [PIX_W-1:0]  wcol_q;

  logic [CNT_W-1:0]  col_q, col_d, row_q, row_d;
  logic [ADDR_W-1:0] rbase_q, rbase_d, pix_q, pix_d;
  logic [ADDR_W-1:0] cur_rbase, cur_pix;

  logic adv, first, in_frame, visible, hit, col_wrap, row_wrap;

  csb_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      pixel_q <= pixel_i;
    end
  end

  // position tracking and clip test
  always_comb begin
    first     = (col_q == '0) && (row_q == '0);
    cur_rbase = first ? cfg.base : rbase_q;
    cur_pix   = first ? cfg.base : pix_q;
    in_frame  = ((SUM_W'(cfg.dest_x) + SUM_W'(col_q)) < SUM_W'(cfg.fcols))
             && ((SUM_W'(cfg.dest_y) + SUM_W'(row_q)) < SUM_W'(cfg.frows));
    visible   = !(cfg.zero_is_clear && (pixel_q == '0));
    hit       = in_frame && visible;
    col_wrap  = (SUM_W'(col_q) + SUM_W'(1)) >= SUM_W'(cfg.scols);
    row_wrap  = (SUM_W'(row_q) + SUM_W'(1)) >= SUM_W'(cfg.srows);
    waddr_d   = cur_pix;
    if (col_wrap) begin
      col_d   = '0;
      row_d   = row_wrap ? '0 : row_q + CNT_W'(1);
      rbase_d = cur_rbase + ADDR_W'(cfg.fcols);
      pix_d   = rbase_d;
    end else begin
      col_d   = col_q + CNT_W'(1);
      row_d   = row_q;
      rbase_d = cur_rbase;
      pix_d   = cur_pix + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      rbase_q <= '0;
      pix_q   <= '0;
    end else if (adv) begin
      col_q   <= col_d;
      row_q   <= row_d;
      rbase_q <= rbase_d;
      pix_q   <= pix_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= hit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && hit) begin
      waddr_q <= waddr_d;
      wcol_q  <= pixel_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_addr_o   = waddr_q;
  assign write_colour_o = wcol_q;

  a_rise_from_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("write word appeared without a processed pixel");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room downstream");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !col_wrap |=> col_q == $past(col_q) + CNT_W'(1))
    else $error("column counter did not advance");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(col_q) && $stable(row_q) && $stable(pix_q))
    else $error("position changed without a processed pixel");

endmodule
